>>> rtl/core/assert_macros.svh
// Assertion macros shared by the scoreboard modules.
// Each macro takes the label, the clock and the active-low reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_i, rstn_i, cond) \
	`ASSERT_IMPLY(lbl, clk_i, rstn_i, 1'b1, cond)

`endif

>>> rtl/core/fcs_pkg.sv
package fcs_pkg;

	localparam int SLOTS = 64;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam int REQ_W      = 2;
	localparam int ACTOR_W    = 16;
	localparam int OCC_W      = 32;
	localparam int KEY_W      = ACTOR_W + OCC_W;
	localparam int CASE_W     = 8;
	localparam int XFER_W     = 16;
	localparam int STATUS_W   = 3;
	localparam int SLOT_OUT_W = 6;

	localparam int S_DATA_W = 72;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 64;
	localparam int M_USER_W = 4;

	typedef logic [REQ_W-1:0] req_t;
	localparam req_t REQ_COMMIT = 2'd0;
	localparam req_t REQ_PHYS   = 2'd1;
	localparam req_t REQ_XFER   = 2'd2;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_DUP      = 3'd1;
	localparam status_t ST_UNKNOWN  = 3'd2;
	localparam status_t ST_PHYS     = 3'd3;
	localparam status_t ST_TOO_MANY = 3'd4;
	localparam status_t ST_FULL     = 3'd5;

	// Per-slot bookkeeping held in the record memory.
	typedef struct packed {
		logic [CASE_W-1:0] case_id;
		logic [XFER_W-1:0] expected;
		logic [XFER_W-1:0] done_count;
		logic              physical_done;
	} rec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic match;
		logic look;
		logic exec;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} sts_t;

	// Write port of the key store.
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
	} cam_wr_t;

endpackage

>>> rtl/core/fcs_ctrl.sv
`include "assert_macros.svh"

module fcs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  fcs_pkg::sts_t sts,
	output fcs_pkg::cmd_t cmd
);
	import fcs_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MATCH = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_MATCH;
				end
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_d   = S_LOOK;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				// Hold the update until the result register can take the beat.
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_ALWAYS(a_cmd_onehot, clk, arst_n, $onehot0({cmd.load, cmd.match, cmd.look, cmd.exec}))
	`ASSERT_IMPLY(a_load_then_match, clk, arst_n, $past(cmd.load) && !$past(!arst_n), cmd.match)

endmodule

>>> rtl/core/fcs_cam.sv
`include "assert_macros.svh"

module fcs_cam (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          match_en,
	input  logic [fcs_pkg::KEY_W-1:0]     key,
	input  fcs_pkg::cam_wr_t              cam_wr,
	output logic                          hit,
	output logic [fcs_pkg::IDX_W-1:0]     hit_idx
);
	import fcs_pkg::*;

	logic [KEY_W-1:0] key_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] match_q;

	always_ff @(posedge clk) begin
		if (cam_wr.set) begin
			key_q[cam_wr.idx] <= cam_wr.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			match_q <= '0;
		end else begin
			if (cam_wr.set) begin
				valid_q[cam_wr.idx] <= 1'b1;
			end else if (cam_wr.clr) begin
				valid_q[cam_wr.idx] <= 1'b0;
			end
			if (match_en) begin
				for (int i = 0; i < SLOTS; i++) begin
					match_q[i] <= valid_q[i] && (key_q[i] == key);
				end
			end
		end
	end

	// At most one entry matches, so an OR of the indices encodes it.
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (match_q[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign hit = |match_q;

	`ASSERT_ALWAYS(a_match_unique, clk, arst_n, $onehot0(match_q))
	`ASSERT_ALWAYS(a_wr_exclusive, clk, arst_n, !(cam_wr.set && cam_wr.clr))
	`ASSERT_IMPLY(a_alloc_free_slot, clk, arst_n, cam_wr.set, !valid_q[cam_wr.idx])

endmodule

>>> rtl/core/fcs_dp.sv
`include "assert_macros.svh"

module fcs_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fcs_pkg::cmd_t                    cmd,
	output fcs_pkg::sts_t                    sts,
	input  logic [fcs_pkg::S_DATA_W-1:0]     s_tdata,
	input  logic [fcs_pkg::S_USER_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fcs_pkg::M_DATA_W-1:0]     m_tdata,
	output logic [fcs_pkg::M_USER_W-1:0]     m_tuser,
	output logic [fcs_pkg::KEY_W-1:0]        key,
	input  logic                             hit,
	input  logic [fcs_pkg::IDX_W-1:0]        hit_idx,
	output fcs_pkg::cam_wr_t                 cam_wr
);
	import fcs_pkg::*;

	// Captured request.
	req_t              req_q;
	logic [ACTOR_W-1:0] actor_q;
	logic [OCC_W-1:0]   occ_q;
	logic [CASE_W-1:0]  case_q;
	logic [XFER_W-1:0]  xfer_q;

	// Lookup results.
	logic             hit_q;
	logic [IDX_W-1:0] idx_q;
	rec_t             rec_q;
	logic [IDX_W-1:0] top_q;

	// Stores and counters.
	rec_t             rec_mem   [SLOTS];
	logic [IDX_W-1:0] stack_mem [SLOTS];
	logic [CNT_W-1:0] free_count_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] top_ptr;

	// Result register.
	logic                  m_tvalid_q;
	status_t               status_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                  retired_q;
	logic [ACTOR_W-1:0]    r_actor_q;
	logic [OCC_W-1:0]      r_occ_q;
	logic [CASE_W-1:0]     r_case_q;

	// Update decisions.
	status_t          status;
	logic [IDX_W-1:0] slot_sel;
	logic             got;
	logic             pop;
	logic             take_new;
	logic             retire;
	logic             push;
	logic             rec_we;
	rec_t             rec_wr;
	logic [XFER_W-1:0] done_inc;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= s_tuser[REQ_W-1:0];
			actor_q <= s_tdata[15:0];
			occ_q   <= s_tdata[47:16];
			case_q  <= s_tdata[55:48];
			xfer_q  <= s_tdata[71:56];
		end
	end

	assign key     = {occ_q, actor_q};
	assign top_ptr = free_count_q - CNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			top_q <= stack_mem[top_ptr[IDX_W-1:0]];
		end
		if (cmd.exec && push) begin
			stack_mem[free_count_q[IDX_W-1:0]] <= slot_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_q <= hit;
			idx_q <= hit_idx;
			rec_q <= rec_mem[hit_idx];
		end
		if (cmd.exec && rec_we) begin
			rec_mem[slot_sel] <= rec_wr;
		end
	end

	assign done_inc = rec_q.done_count + XFER_W'(1);

	always_comb begin
		status   = ST_OK;
		slot_sel = '0;
		got      = 1'b0;
		pop      = 1'b0;
		take_new = 1'b0;
		retire   = 1'b0;
		rec_we   = 1'b0;
		rec_wr   = rec_q;
		case (req_q)
			REQ_COMMIT: begin
				if (hit_q) begin
					status   = ST_DUP;
					slot_sel = idx_q;
				end else if (free_count_q != '0) begin
					slot_sel = top_q;
					pop      = 1'b1;
					got      = 1'b1;
				end else if (used_q < CNT_W'(SLOTS)) begin
					slot_sel = used_q[IDX_W-1:0];
					take_new = 1'b1;
					got      = 1'b1;
				end else begin
					status = ST_FULL;
				end
				if (got) begin
					rec_we               = 1'b1;
					rec_wr.case_id       = case_q;
					rec_wr.expected      = xfer_q;
					rec_wr.done_count    = '0;
					rec_wr.physical_done = 1'b0;
				end
			end
			REQ_PHYS: begin
				if (!hit_q) begin
					status = ST_UNKNOWN;
				end else begin
					slot_sel = idx_q;
					if ((rec_q.case_id != case_q) || rec_q.physical_done) begin
						status = ST_PHYS;
					end else begin
						rec_we               = 1'b1;
						rec_wr.physical_done = 1'b1;
						retire               = (rec_q.done_count == rec_q.expected);
					end
				end
			end
			REQ_XFER: begin
				if (!hit_q) begin
					status = ST_UNKNOWN;
				end else begin
					slot_sel = idx_q;
					if (rec_q.done_count == rec_q.expected) begin
						status = ST_TOO_MANY;
					end else begin
						rec_we            = 1'b1;
						rec_wr.done_count = done_inc;
						retire            = rec_q.physical_done && (done_inc == rec_q.expected);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign push = retire && (free_count_q < CNT_W'(SLOTS));

	assign cam_wr.set = cmd.exec && got;
	assign cam_wr.clr = cmd.exec && retire;
	assign cam_wr.idx = slot_sel;
	assign cam_wr.key = key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= '0;
			used_q       <= '0;
		end else if (cmd.exec) begin
			if (pop) begin
				free_count_q <= free_count_q - CNT_W'(1);
			end else if (push) begin
				free_count_q <= free_count_q + CNT_W'(1);
			end
			if (take_new) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.exec) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= status;
			slot_q    <= SLOT_OUT_W'(slot_sel);
			retired_q <= retire;
			r_actor_q <= retire ? actor_q : '0;
			r_occ_q   <= retire ? occ_q : '0;
			r_case_q  <= retire ? rec_q.case_id : '0;
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = {2'b00, r_case_q, r_occ_q, r_actor_q, slot_q};
	assign m_tuser      = {retired_q, status_q};

	`ASSERT_ALWAYS(a_free_le_used, clk, arst_n, free_count_q <= used_q)
	`ASSERT_IMPLY(a_exec_has_room, clk, arst_n, cmd.exec, !m_tvalid_q || m_tready)
	`ASSERT_IMPLY(a_retire_ok, clk, arst_n, cmd.exec && retire, status == ST_OK)

endmodule

>>> rtl/core/firing_completion_scoreboard.sv
// Each request passes through the key compare, then the encode and record read, then the
// read-modify-write of the record memory and free stack, before its result beat is registered;
// a new request beat is accepted only once the previous one has finished its update.
// A stalled result beat holds the update of the following request until it is taken.
// Reset (arst_n low, asynchronous) empties the table: all slots invalid, no freed slots,
// no slots used, no result pending.
module firing_completion_scoreboard (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata, from bit 0: actor_id[16], occurrence[32], case_id[8], expected_transfers[16]
	input  logic [fcs_pkg::S_DATA_W-1:0]  s_tdata,
	// s_tuser: req_type[2]
	input  logic [fcs_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata, from bit 0: slot_index[6], retired_actor[16], retired_occurrence[32],
	// retired_case[8], two zero bits of padding
	output logic [fcs_pkg::M_DATA_W-1:0]  m_tdata,
	// m_tuser, from bit 0: status[3], retired[1]
	output logic [fcs_pkg::M_USER_W-1:0]  m_tuser
);
	import fcs_pkg::*;

	// The controller walks each request through capture, key compare, lookup and update.
	// The datapath holds the captured request, the record memory, the free stack, the
	// allocation counters and the result register; the key store sits beside it and
	// answers which valid slot, if any, holds the requested firing key.
	cmd_t             cmd;
	sts_t             sts;
	logic [KEY_W-1:0] key;
	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	cam_wr_t          cam_wr;

	fcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Keys live in flip-flops so that every slot is compared in the same cycle.
	fcs_cam u_cam (
		.clk      (clk),
		.arst_n   (arst_n),
		.match_en (cmd.match),
		.key      (key),
		.cam_wr   (cam_wr),
		.hit      (hit),
		.hit_idx  (hit_idx)
	);

	// The result register parts the two sides: a new request is taken while the
	// previous result beat still waits for the consumer.
	fcs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.key      (key),
		.hit      (hit),
		.hit_idx  (hit_idx),
		.cam_wr   (cam_wr)
	);

endmodule

>>> tb/tb_firing_completion_scoreboard.sv
`timescale 1ns / 1ps

// Testbench for the firing completion scoreboard.
// A sender process offers request beats, and every accepted beat is run
// through a predictor of the scoreboard table in this module. The predicted
// outcome is queued. A checker process takes each result beat and compares it
// field by field with the oldest queued outcome. Both sides idle at random.
// Named test tasks, called in turn, cover the directed corner cases, random
// traffic that is mostly well formed, a long output stall, and a pass that
// fills the table to the brim and then drains it again.
module tb_firing_completion_scoreboard;

	import fcs_pkg::*;

	// The unused request code is not named in the package.
	localparam req_t REQ_UNUSED = 2'd3;

	// Cycles without any handshake on either side before the run is abandoned.
	// The longest correct stretch is the long output stall.
	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 400;

	// One result of the scoreboard, as predicted.
	typedef struct packed {
		status_t             status;
		logic [SLOT_OUT_W-1:0] slot;
		logic                retired;
		logic [ACTOR_W-1:0]  actor;
		logic [OCC_W-1:0]    occ;
		logic [CASE_W-1:0]   case_no;
	} firing_outcome_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [S_USER_W-1:0] s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;

	// Predicted contents of the firing table and its free slot stack.
	bit                 tbl_valid  [SLOTS];
	logic [ACTOR_W-1:0] tbl_actor  [SLOTS];
	logic [OCC_W-1:0]   tbl_occ    [SLOTS];
	logic [CASE_W-1:0]  tbl_case   [SLOTS];
	logic [XFER_W-1:0]  tbl_expect [SLOTS];
	logic [XFER_W-1:0]  tbl_done   [SLOTS];
	bit                 tbl_phys   [SLOTS];
	int                 freed_slots[SLOTS];
	int                 freed_depth = 0;
	int                 slots_used  = 0;

	firing_outcome_t outcomes_due[$];
	int              mismatches = 0;

	// When set, neither side inserts idle cycles.
	bit steady = 1'b0;
	// Cycles for which the receiver is to hold off; counted down by the receiver.
	int hold_left = 0;

	always #10 clk = ~clk;

	firing_completion_scoreboard dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// A firing retires once its physical completion has come and all of its
	// transfers are done. Its slot then goes on top of the free stack.
	function automatic void retire_if_complete(int s, inout firing_outcome_t r);
		if (tbl_phys[s] && tbl_done[s] == tbl_expect[s]) begin
			r.retired = 1'b1;
			r.actor   = tbl_actor[s];
			r.occ     = tbl_occ[s];
			r.case_no = tbl_case[s];
			tbl_valid[s] = 1'b0;
			if (freed_depth < SLOTS) begin
				freed_slots[freed_depth] = s;
				freed_depth++;
			end
		end
	endfunction

	// Applies one accepted request to the predicted table and returns the result
	// the scoreboard should give for it. Errors leave the table as it was.
	function automatic firing_outcome_t score_request(req_t rq, logic [ACTOR_W-1:0] a,
			logic [OCC_W-1:0] o, logic [CASE_W-1:0] c, logic [XFER_W-1:0] x);
		firing_outcome_t r;
		int hit;
		int s;
		r   = '0;
		hit = -1;
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_actor[i] == a && tbl_occ[i] == o)
				hit = i;
		case (rq)
			REQ_COMMIT: begin
				if (hit >= 0) begin
					r.status = ST_DUP;
					r.slot   = hit[SLOT_OUT_W-1:0];
				end else begin
					// The most recently freed slot wins over a slot never used.
					s = -1;
					if (freed_depth > 0) begin
						freed_depth--;
						s = freed_slots[freed_depth];
					end else if (slots_used < SLOTS) begin
						s = slots_used;
						slots_used++;
					end else begin
						r.status = ST_FULL;
					end
					if (s >= 0) begin
						r.slot        = s[SLOT_OUT_W-1:0];
						tbl_valid[s]  = 1'b1;
						tbl_actor[s]  = a;
						tbl_occ[s]    = o;
						tbl_case[s]   = c;
						tbl_expect[s] = x;
						tbl_done[s]   = '0;
						tbl_phys[s]   = 1'b0;
					end
				end
			end
			REQ_PHYS: begin
				if (hit < 0) begin
					r.status = ST_UNKNOWN;
				end else begin
					r.slot = hit[SLOT_OUT_W-1:0];
					// A wrong case and a second physical completion are both refused.
					if (tbl_case[hit] != c || tbl_phys[hit]) begin
						r.status = ST_PHYS;
					end else begin
						tbl_phys[hit] = 1'b1;
						retire_if_complete(hit, r);
					end
				end
			end
			REQ_XFER: begin
				if (hit < 0) begin
					r.status = ST_UNKNOWN;
				end else begin
					r.slot = hit[SLOT_OUT_W-1:0];
					if (tbl_done[hit] == tbl_expect[hit]) begin
						r.status = ST_TOO_MANY;
					end else begin
						tbl_done[hit] = tbl_done[hit] + 1'b1;
						retire_if_complete(hit, r);
					end
				end
			end
			default: ;	// the unused code answers ok, slot zero, nothing retired
		endcase
		return r;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Transfer counts are mostly small, so that firings retire; a few are drawn
	// from the whole range and such firings stay in the table for good.
	function automatic logic [XFER_W-1:0] pick_transfer_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return XFER_W'($urandom_range(0, 3));
		if (r < 95)
			return XFER_W'($urandom_range(4, 12));
		return XFER_W'($urandom);
	endfunction

	// A random live slot, or -1. With near_done set, only firings that need at
	// most sixteen more transfers are considered.
	function automatic int pick_slot(bit near_done);
		int n;
		int k;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && (!near_done || tbl_expect[i] - tbl_done[i] <= 16))
				n++;
		if (n == 0)
			return -1;
		k = $urandom_range(0, n - 1);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && (!near_done || tbl_expect[i] - tbl_done[i] <= 16)) begin
				if (k == 0)
					return i;
				k--;
			end
		return -1;
	endfunction

	// Offers one request beat and waits for the handshake. The valid line is only
	// lowered when an idle gap follows, so back-to-back beats keep it high.
	task automatic send_request(req_t rq, logic [ACTOR_W-1:0] a, logic [OCC_W-1:0] o,
			logic [CASE_W-1:0] c, logic [XFER_W-1:0] x);
		int gap;
		firing_outcome_t due;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {x, c, o, a};
		s_tuser  <= rq;
		do @(posedge clk); while (!s_tready);
		due          = score_request(rq, a, o, c, x);
		outcomes_due = {outcomes_due, due};
	endtask

	// A commit of a firing under a fresh random key.
	task automatic send_fresh_commit(logic [XFER_W-1:0] x);
		send_request(REQ_COMMIT, ACTOR_W'($urandom), OCC_W'($urandom), CASE_W'($urandom), x);
	endtask

	// One random request. Most requests act on a live firing and are well formed,
	// so that firings run their whole course; the rest are errors and noise.
	task automatic send_random_item();
		int live_n;
		int s;
		int r;
		live_n = 0;
		for (int i = 0; i < SLOTS; i++)
			live_n += tbl_valid[i];
		s = pick_slot(1'b0);
		r = $urandom_range(0, 99);
		// Commit new firings freely while the table is lightly used.
		if (s < 0 || r < ((live_n < 40) ? 28 : 6)) begin
			send_fresh_commit(pick_transfer_count());
		end else begin
			r = $urandom_range(0, 99);
			if (r < 5)
				send_request(REQ_COMMIT, tbl_actor[s], tbl_occ[s], CASE_W'($urandom),
					XFER_W'($urandom));
			else if (r < 32)
				send_request(REQ_PHYS, tbl_actor[s], tbl_occ[s], tbl_case[s],
					XFER_W'($urandom));
			else if (r < 36)
				send_request(REQ_PHYS, tbl_actor[s], tbl_occ[s],
					tbl_case[s] ^ CASE_W'($urandom_range(1, 255)), XFER_W'($urandom));
			else if (r < 90)
				send_request(REQ_XFER, tbl_actor[s], tbl_occ[s], CASE_W'($urandom),
					XFER_W'($urandom));
			else if (r < 96)
				send_request($urandom_range(0, 1) ? REQ_PHYS : REQ_XFER, ACTOR_W'($urandom),
					OCC_W'($urandom), CASE_W'($urandom), XFER_W'($urandom));
			else
				send_request(REQ_UNUSED, ACTOR_W'($urandom), OCC_W'($urandom),
					CASE_W'($urandom), XFER_W'($urandom));
		end
	endtask

	// The sender stops and waits until every predicted result has come back.
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
	endtask

	// Hand-picked cases: field extremes, every request type and every status but full.
	task automatic test_directed_cases();
		// A firing with no transfers retires on its physical completion alone.
		send_request(REQ_COMMIT, 16'h0000, 32'h0000_0000, 8'h00, 16'h0000);
		send_request(REQ_XFER,   16'h0000, 32'h0000_0000, 8'h00, 16'h0000);	// too many
		send_request(REQ_PHYS,   16'h0000, 32'h0000_0000, 8'h01, 16'h0000);	// wrong case
		send_request(REQ_PHYS,   16'h0000, 32'h0000_0000, 8'h00, 16'h0000);	// retires
		send_request(REQ_PHYS,   16'h0000, 32'h0000_0000, 8'h00, 16'h0000);	// now unknown
		// All-ones key reuses the freed slot; transfers come before the physical end.
		send_request(REQ_COMMIT, 16'hffff, 32'hffff_ffff, 8'hff, 16'h0002);
		send_request(REQ_COMMIT, 16'hffff, 32'hffff_ffff, 8'h00, 16'hffff);	// duplicate
		send_request(REQ_XFER,   16'hffff, 32'hffff_ffff, 8'hff, 16'hffff);
		send_request(REQ_XFER,   16'hffff, 32'hffff_ffff, 8'hff, 16'hffff);
		send_request(REQ_XFER,   16'hffff, 32'hffff_ffff, 8'hff, 16'hffff);	// too many
		send_request(REQ_PHYS,   16'hffff, 32'hffff_ffff, 8'hff, 16'h0000);	// retires
		// Physical end first, a repeat of it, and the last transfer retiring it.
		send_request(REQ_COMMIT, 16'h1234, 32'h0000_8000, 8'h5a, 16'h0001);
		send_request(REQ_PHYS,   16'h1234, 32'h0000_8000, 8'h5a, 16'h0000);
		send_request(REQ_PHYS,   16'h1234, 32'h0000_8000, 8'h5a, 16'h0000);	// repeated
		send_request(REQ_XFER,   16'h1234, 32'h0000_8000, 8'h5a, 16'h0000);	// retires
		// The largest transfer count; this firing stays in the table.
		send_request(REQ_COMMIT, 16'h8001, 32'h7fff_ffff, 8'h80, 16'hffff);
		send_request(REQ_XFER,   16'h8001, 32'h7fff_ffff, 8'h80, 16'h0000);
		// The unused request type, and a transfer for a firing never committed.
		send_request(REQ_UNUSED, 16'hffff, 32'hffff_ffff, 8'hff, 16'hffff);
		send_request(REQ_XFER,   16'h0042, 32'hdead_beef, 8'h00, 16'h0000);
	endtask

	// Random traffic, with a stretch without idle cycles every now and then.
	task automatic test_random_traffic(int n);
		for (int i = 0; i < n; i++) begin
			steady = ((i / 50) % 5 == 4);
			send_random_item();
		end
		steady = 1'b0;
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so
	// that the result path fills and the request side has to stall.
	task automatic test_output_stall();
		hold_left = LONG_HOLD;
		repeat (40) send_random_item();
	endtask

	// Fills every slot, knocks on the full table, then retires firings in random
	// order with the odd new commit in between, so that freed slots are reused
	// straight off the top of the stack.
	task automatic test_table_full();
		int s;
		int guard;
		while (freed_depth > 0 || slots_used < SLOTS)
			send_fresh_commit(XFER_W'($urandom_range(0, 2)));
		send_fresh_commit(XFER_W'($urandom_range(0, 2)));
		s = pick_slot(1'b0);
		send_request(REQ_COMMIT, tbl_actor[s], tbl_occ[s], CASE_W'($urandom), 16'h0000);
		guard = 0;
		s = pick_slot(1'b1);
		while (s >= 0 && guard < 600) begin
			if ($urandom_range(0, 99) < 12)
				send_fresh_commit(XFER_W'($urandom_range(0, 2)));
			else if (!tbl_phys[s] && (tbl_done[s] == tbl_expect[s] || $urandom_range(0, 1)))
				send_request(REQ_PHYS, tbl_actor[s], tbl_occ[s], tbl_case[s],
					XFER_W'($urandom));
			else
				send_request(REQ_XFER, tbl_actor[s], tbl_occ[s], CASE_W'($urandom),
					XFER_W'($urandom));
			guard++;
			s = pick_slot(1'b1);
		end
	endtask

	// Receiver: a long hold when one is asked for, otherwise random gaps.
	initial begin
		int gap;
		gap = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (gap > 0) begin
				m_tready <= 1'b0;
				gap--;
			end else begin
				m_tready <= 1'b1;
				gap = steady ? 0 : pick_gap();
			end
		end
	end

	// Checker: every result beat is matched against the oldest predicted outcome.
	initial begin
		firing_outcome_t want;
		firing_outcome_t got;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.status  = m_tuser[2:0];
				got.retired = m_tuser[3];
				got.slot    = m_tdata[5:0];
				got.actor   = m_tdata[21:6];
				got.occ     = m_tdata[53:22];
				got.case_no = m_tdata[61:54];
				if (outcomes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: result beat with none expected: tuser=%h tdata=%h",
							$realtime, m_tuser, m_tdata);
				end else begin
					want = outcomes_due.pop_front();
					if (got.status != want.status || got.slot != want.slot ||
							got.retired != want.retired || got.actor != want.actor ||
							got.occ != want.occ || got.case_no != want.case_no ||
							m_tdata[63:62] != 2'b00) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%t: result mismatch", $realtime);
							$display("  expected status=%0d slot=%0d retired=%0d actor=%h occ=%h case=%h",
								want.status, want.slot, want.retired, want.actor, want.occ,
								want.case_no);
							$display("  actual   status=%0d slot=%0d retired=%0d actor=%h occ=%h case=%h pad=%b",
								got.status, got.slot, got.retired, got.actor, got.occ,
								got.case_no, m_tdata[63:62]);
						end
					end
				end
			end
		end
	end

	// Watchdog: too long without a beat on either side means the block is stuck.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("firing_completion_scoreboard test failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		wait_all_results();
		test_random_traffic(450);
		test_output_stall();
		// The sender pauses here until the scoreboard has answered everything.
		wait_all_results();
		test_table_full();
		test_random_traffic(550);
		wait_all_results();

		// Keep watching for any stray result beat before the verdict.
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("firing_completion_scoreboard test passed");
		else
			$display("firing_completion_scoreboard test failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/fcs_pkg.sv
rtl/core/fcs_ctrl.sv
rtl/core/fcs_cam.sv
rtl/core/fcs_dp.sv
rtl/core/firing_completion_scoreboard.sv
tb/tb_firing_completion_scoreboard.sv
